[rtl/core/mavg_pkg.sv]
// Shared constants, types and register codes for the moving or exponential average block.
package mavg_pkg;

	// Sizing of the sample path and the history ring.
	localparam int WINDOW_MAX  = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int SLOT_W      = $clog2(WINDOW_MAX);
	localparam int WLEN_W      = 7;
	localparam int SUM_W       = SAMPLE_BITS + SLOT_W;
	localparam int DCNT_W      = $clog2(SUM_W);
	localparam int MIX_W       = 17;
	localparam int DIFF_W      = SAMPLE_BITS + 1;
	localparam int PROD_W      = DIFF_W + MIX_W + 1;
	localparam int FRAC_BITS   = 16;

	// Register file layout.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WINDOW = 2'd1;
	localparam logic [1:0] REG_MIX    = 2'd2;

	// Reset values and usable limits of the registers.
	localparam logic              MODE_RESET   = 1'b0;
	localparam logic [WLEN_W-1:0] WINDOW_RESET = WLEN_W'(4);
	localparam logic [MIX_W-1:0]  MIX_RESET    = MIX_W'(32768);
	localparam logic [MIX_W-1:0]  MIX_ONE      = MIX_W'(65536);
	localparam logic [WLEN_W-1:0] WINDOW_MIN   = WLEN_W'(2);
	localparam logic [WLEN_W-1:0] WINDOW_TOP   = WLEN_W'(WINDOW_MAX);

	// Filter mode codes.
	localparam logic MODE_MOVING      = 1'b0;
	localparam logic MODE_EXPONENTIAL = 1'b1;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MA_UPD,
		ST_DIV_LOAD,
		ST_DIV_STEP,
		ST_EXP_MUL,
		ST_EXP_ADD,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take_sample;
		logic ma_update;
		logic div_load;
		logic div_step;
		logic exp_first;
		logic exp_mul;
		logic exp_add;
		logic load_out;
		logic out_sel_exp;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic produce;
		logic div_last;
		logic first_seen;
	} stat_t;

endpackage

[rtl/core/moving_or_exponential_average.sv]
// Top level: register port, controller and datapath of the average filter.
//
// Usage: one signed sample word enters on in_valid/in_ready; one filtered
// word leaves on out_valid/out_ready. Registers are written over the APB
// port: filter_mode at 0x0, window_length at 0x4, mix_factor at 0x8.
// Any register write restarts the fill count and the first-sample mark.
// Moving-average mode: after acceptance a word passes the ring update, the
// divider load, the 22-step restoring divider and the output state before the
// next acceptance when it produces a result; while the window is still filling
// and no word is produced, only the ring update comes between acceptances.
// Exponential mode: a word passes the registered multiply and add and then the
// output state; the first word is taken as the smoothed value without them.
// One word is in work at a time. The output register holds a finished word
// while the receiver stalls, and the next sample is still accepted; its own
// result waits in the controller until the output register drains.
// Reset clears the controller, sum, fill count and smoothed value, and loads
// the register reset values. The history ring needs no clearing.
module moving_or_exponential_average (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [mavg_pkg::PADDR_W-1:0]            paddr,
	input  logic [mavg_pkg::PDATA_W-1:0]            pwdata,
	output logic [mavg_pkg::PDATA_W-1:0]            prdata,
	output logic                                    pready,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [mavg_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [mavg_pkg::SAMPLE_BITS-1:0] filtered
);
	import mavg_pkg::*;

	logic              mode_q;
	logic [WLEN_W-1:0] window_q;
	logic [MIX_W-1:0]  mix_q;
	logic              wr_en;
	logic              restart;
	logic [WLEN_W-1:0] win;
	logic [MIX_W-1:0]  mix;
	cmd_t              cmd;
	stat_t             stat;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// A write to any defined register restarts the averaging.
	assign restart = wr_en && ((paddr[3:2] == REG_MODE) || (paddr[3:2] == REG_WINDOW)
		|| (paddr[3:2] == REG_MIX));

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RESET;
			window_q <= WINDOW_RESET;
			mix_q    <= MIX_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_MODE:   mode_q   <= pwdata[0];
				REG_WINDOW: window_q <= pwdata[WLEN_W-1:0];
				REG_MIX:    mix_q    <= pwdata[MIX_W-1:0];
				default:    ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (paddr[3:2])
			REG_MODE:   prdata = PDATA_W'(mode_q);
			REG_WINDOW: prdata = PDATA_W'(window_q);
			REG_MIX:    prdata = PDATA_W'(mix_q);
			default:    prdata = '0;
		endcase
	end

	// Window and mix weight limited to their usable ranges.
	assign win = (window_q < WINDOW_MIN) ? WINDOW_MIN :
		(window_q > WINDOW_TOP) ? WINDOW_TOP : window_q;
	assign mix = (mix_q > MIX_ONE) ? MIX_ONE : mix_q;

	mavg_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.filter_mode (mode_q),
		.stat        (stat),
		.cmd         (cmd)
	);

	mavg_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.restart  (restart),
		.win      (win),
		.mix      (mix),
		.sample   (sample),
		.filtered (filtered)
	);

endmodule

[rtl/core/mavg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mavg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/mavg_ctrl.sv]
// Controller state machine that sequences the average and mix datapath.
module mavg_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  logic           filter_mode,
	input  mavg_pkg::stat_t stat,
	output mavg_pkg::cmd_t  cmd
);
	import mavg_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// The output register can take a new word when empty or being drained.
	assign out_free = !out_valid_q || out_ready;

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.out_sel_exp = (filter_mode == MODE_EXPONENTIAL);
		in_ready        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_sample = 1'b1;
					state_d = (filter_mode == MODE_EXPONENTIAL) ? ST_EXP_MUL : ST_MA_UPD;
				end
			end
			ST_MA_UPD: begin
				cmd.ma_update = 1'b1;
				state_d = stat.produce ? ST_DIV_LOAD : ST_IDLE;
			end
			ST_DIV_LOAD: begin
				cmd.div_load = 1'b1;
				state_d = ST_DIV_STEP;
			end
			ST_DIV_STEP: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_OUT;
				end
			end
			ST_EXP_MUL: begin
				if (!stat.first_seen) begin
					cmd.exp_first = 1'b1;
					state_d = ST_OUT;
				end else begin
					cmd.exp_mul = 1'b1;
					state_d = ST_EXP_ADD;
				end
			end
			ST_EXP_ADD: begin
				cmd.exp_add = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/core/mavg_dp.sv]
// Datapath: history ring, running sum, restoring divider and exponential mix.
module mavg_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mavg_pkg::cmd_t                       cmd,
	output mavg_pkg::stat_t                      stat,
	input  logic                                 restart,
	input  logic [mavg_pkg::WLEN_W-1:0]          win,
	input  logic [mavg_pkg::MIX_W-1:0]           mix,
	input  logic signed [mavg_pkg::SAMPLE_BITS-1:0] sample,
	output logic signed [mavg_pkg::SAMPLE_BITS-1:0] filtered
);
	import mavg_pkg::*;

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic [SLOT_W-1:0]             slot_q;
	logic [WLEN_W-1:0]             fill_q;
	logic                          first_q;
	logic [WLEN_W-1:0]             rem_q;
	logic [SUM_W-1:0]              quo_q;
	logic [DCNT_W-1:0]             dcnt_q;
	logic                          neg_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [SAMPLE_BITS-1:0] filtered_q;

	logic signed [SAMPLE_BITS-1:0] old_x;
	logic                          full;
	logic signed [SUM_W-1:0]       sum_d;
	logic [WLEN_W-1:0]             slot_inc;
	logic [WLEN_W:0]               trial;
	logic                          trial_ok;
	logic [SUM_W-1:0]              quo_signed;
	logic signed [DIFF_W-1:0]      diff;
	logic signed [DIFF_W-1:0]      step;
	logic signed [DIFF_W-1:0]      y_sum;

	// History ring, read at the write slot so the oldest sample is ready after acceptance.
	mavg_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (WINDOW_MAX)
	) u_ring (
		.clk   (clk),
		.we    (cmd.ma_update),
		.waddr (slot_q),
		.wdata (x_q),
		.raddr (slot_q),
		.rdata (old_x)
	);

	// Running sum update and ring bookkeeping.
	assign full     = (fill_q >= win);
	assign sum_d    = sum_q - (full ? SUM_W'(old_x) : '0) + SUM_W'(x_q);
	assign slot_inc = {1'b0, slot_q} + WLEN_W'(1);

	// One restoring division step: quotient bits shift in from the right.
	assign trial    = {rem_q, quo_q[SUM_W-1]};
	assign trial_ok = (trial >= {1'b0, win});

	// Sign-corrected quotient.
	assign quo_signed = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;

	// Exponential mix terms.
	assign diff  = DIFF_W'(x_q) - DIFF_W'(y_q);
	assign step  = prod_q[FRAC_BITS +: DIFF_W];
	assign y_sum = DIFF_W'(y_q) + step;

	assign stat.produce    = full || (fill_q + WLEN_W'(1) == win);
	assign stat.div_last   = (dcnt_q == DCNT_W'(SUM_W - 1));
	assign stat.first_seen = first_q;

	// Control-like state: fill count, slot, first-sample mark and running sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			slot_q  <= '0;
			fill_q  <= '0;
			first_q <= 1'b0;
			y_q     <= '0;
		end else if (restart) begin
			sum_q   <= '0;
			slot_q  <= '0;
			fill_q  <= '0;
			first_q <= 1'b0;
		end else begin
			if (cmd.ma_update) begin
				sum_q  <= sum_d;
				slot_q <= (slot_inc == win) ? '0 : slot_inc[SLOT_W-1:0];
				if (!full) begin
					fill_q <= fill_q + WLEN_W'(1);
				end
			end
			if (cmd.exp_first) begin
				y_q     <= x_q;
				first_q <= 1'b1;
			end
			if (cmd.exp_add) begin
				y_q <= y_sum[SAMPLE_BITS-1:0];
			end
		end
	end

	// Payload registers: sample, divider, product and output word.
	always_ff @(posedge clk) begin
		if (cmd.take_sample) begin
			x_q <= sample;
		end
		if (cmd.div_load) begin
			neg_q  <= sum_q[SUM_W-1];
			quo_q  <= sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= trial_ok ? WLEN_W'(trial - {1'b0, win}) : trial[WLEN_W-1:0];
			quo_q  <= {quo_q[SUM_W-2:0], trial_ok};
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
		if (cmd.exp_mul) begin
			prod_q <= PROD_W'(diff) * $signed({1'b0, mix});
		end
		if (cmd.load_out) begin
			filtered_q <= cmd.out_sel_exp ? y_q : quo_signed[SAMPLE_BITS-1:0];
		end
	end

	assign filtered = filtered_q;

endmodule
